@@ sv/assert_macros.svh @@
// Assertion macros shared by the allocator RTL.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// same-cycle implication, disabled while reset is asserted
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// next-cycle implication, disabled while reset is asserted
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

@@ sv/fmba_pkg.sv @@
// Shared types and constants for the fit memory block allocator.
// No dependencies; used by fmba_cell and fit_memory_block_allocator.
`default_nettype none
package fmba_pkg;

    // table geometry
    localparam int NUM_BLOCKS = 16;
    localparam int SIZE_BITS  = 16;
    localparam int BIDX_BITS  = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;

    // port field widths
    localparam int LOAD_IDX_W = 4;
    localparam int SIZE_W     = 16;
    localparam int CHOSEN_W   = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // placement policy codes (code 3 falls back to first fit)
    localparam logic [1:0] FIT_FIRST = 2'd0;
    localparam logic [1:0] FIT_BEST  = 2'd1;
    localparam logic [1:0] FIT_WORST = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 2'd1;

    // item actions
    localparam logic ACT_LOAD    = 1'b0;
    localparam logic ACT_REQUEST = 1'b1;

    // search token handed from cell to cell
    typedef struct packed {
        logic                 found;
        logic [BIDX_BITS-1:0] best_idx;
        logic [SIZE_BITS-1:0] best_val;
        logic [SIZE_BITS-1:0] req_size;
    } t_token;

    // write broadcast to the row of cells
    typedef struct packed {
        logic                 en;
        logic [BIDX_BITS-1:0] idx;
        logic [SIZE_BITS-1:0] data;
    } t_cell_wr;

endpackage
`default_nettype wire

@@ sv/fmba_cell.sv @@
// One cell of the allocator chain: holds one block's free size and
// updates the passing search token. Depends on fmba_pkg.
`default_nettype none
module fmba_cell (
    input  wire logic                          i_clk,
    input  wire logic [fmba_pkg::BIDX_BITS-1:0] i_cell_idx,
    input  wire logic                          i_active,
    input  wire logic [1:0]                    i_fit_mode,
    input  wire fmba_pkg::t_token              i_token,
    input  wire fmba_pkg::t_cell_wr            i_wr,
    output      fmba_pkg::t_token              o_token
);
    import fmba_pkg::*;

    logic [SIZE_BITS-1:0] r_free;
    t_token               r_token;
    t_token               n_token;
    logic                 w_fits;
    logic                 w_take;

    // compare this block against the token, keep the better candidate
    always_comb begin
        n_token = i_token;
        w_fits  = i_active && (r_free >= i_token.req_size);
        case (i_fit_mode)
            FIT_BEST:  w_take = w_fits && (!i_token.found || (r_free < i_token.best_val));
            FIT_WORST: w_take = w_fits && (!i_token.found || (r_free > i_token.best_val));
            default:   w_take = w_fits && !i_token.found;
        endcase
        if (w_take) begin
            n_token.found    = 1'b1;
            n_token.best_idx = i_cell_idx;
            n_token.best_val = r_free;
        end
    end

    // token stage and free-size storage
    always_ff @(posedge i_clk) begin
        r_token <= n_token;
        if (i_wr.en && (i_wr.idx == i_cell_idx)) begin
            r_free <= i_wr.data;
        end
    end

    assign o_token = r_token;

endmodule
`default_nettype wire

@@ sv/fit_memory_block_allocator.sv @@
// Fit memory block allocator top level: control, config registers, cell chain.
// Depends on fmba_pkg, fmba_cell and assert_macros.svh.
// Load items give no result; an accepted load writes the free-size table. A request
// moves from ST_IDLE through ST_SCAN (one scan step per cell) to ST_UPDATE, which
// writes the result register once the output is free; the next item is taken only
// back in ST_IDLE. The scan length is set by r_cnt counting one step per cell.
// Reset clears fit_mode, block_count, the controller and the result valid;
// the free-size table is not cleared and must be loaded before it is scanned.
`default_nettype none
`include "assert_macros.svh"
module fit_memory_block_allocator (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    // item input channel
    input  wire logic                            i_in_valid,
    output      logic                            o_in_stall,
    input  wire logic                            i_action,
    input  wire logic [fmba_pkg::LOAD_IDX_W-1:0] i_load_index,
    input  wire logic [fmba_pkg::SIZE_W-1:0]     i_size_value,
    input  wire logic                            i_last_in_batch,
    // result output channel
    output      logic                            o_out_valid,
    input  wire logic                            i_out_stall,
    output      logic                            o_allocated,
    output      logic [fmba_pkg::CHOSEN_W-1:0]   o_chosen_block,
    output      logic [fmba_pkg::SIZE_W-1:0]     o_remaining_size,
    output      logic                            o_end_of_batch,
    // configuration write channel
    input  wire logic                            i_cfg_valid,
    output      logic                            o_cfg_ready,
    input  wire logic [fmba_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [fmba_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import fmba_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_UPDATE
    } t_state;

    t_state                r_state;
    logic [BIDX_BITS-1:0]  r_cnt;
    logic [1:0]            r_fit_mode;
    logic [CFG_DATA_W-1:0] r_block_count;
    logic [SIZE_BITS-1:0]  r_req_size;
    logic                  r_last;
    logic                  r_out_valid;
    logic                  r_allocated;
    logic [CHOSEN_W-1:0]   r_chosen;
    logic [SIZE_W-1:0]     r_remaining;
    logic                  r_end_of_batch;

    t_token                w_chain [NUM_BLOCKS+1];
    logic [NUM_BLOCKS-1:0] w_active;
    t_token                w_last;
    t_cell_wr              w_wr;
    logic                  w_in_xfer;
    logic                  w_req_xfer;
    logic                  w_scan_last;
    logic                  w_grant;
    logic                  w_out_free;
    logic [SIZE_BITS-1:0]  w_remain;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_in_xfer   = i_in_valid && !o_in_stall;
    assign w_req_xfer  = w_in_xfer && (i_action == ACT_REQUEST);
    assign w_scan_last = (r_state == ST_SCAN) && (r_cnt == BIDX_BITS'(NUM_BLOCKS - 1));
    assign w_out_free  = !r_out_valid || !i_out_stall;

    // fresh token entering the first cell
    assign w_chain[0] = '{found: 1'b0, best_idx: '0, best_val: '0, req_size: r_req_size};

    // row of cells; a block takes part when its index is below block_count
    for (genvar k = 0; k < NUM_BLOCKS; k++) begin : g_cell
        assign w_active[k] = (32'(k) < 32'(r_block_count));
        fmba_cell u_cell (
            .i_clk      (i_clk),
            .i_cell_idx (BIDX_BITS'(k)),
            .i_active   (w_active[k]),
            .i_fit_mode (r_fit_mode),
            .i_token    (w_chain[k]),
            .i_wr       (w_wr),
            .o_token    (w_chain[k+1])
        );
    end

    assign w_last   = w_chain[NUM_BLOCKS];
    assign w_remain = w_last.best_val - w_last.req_size;
    assign w_grant  = (r_state == ST_UPDATE) && w_last.found;

    // table write: a load in idle, or the subtraction at the end of a scan
    always_comb begin
        w_wr = '0;
        if (w_in_xfer && (i_action == ACT_LOAD) && (32'(i_load_index) < NUM_BLOCKS)) begin
            w_wr.en   = 1'b1;
            w_wr.idx  = BIDX_BITS'(i_load_index);
            w_wr.data = SIZE_BITS'(i_size_value);
        end else if (w_grant && w_out_free) begin
            w_wr.en   = 1'b1;
            w_wr.idx  = w_last.best_idx;
            w_wr.data = w_remain;
        end
    end

    // controller, configuration registers and result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state       <= ST_IDLE;
            r_cnt         <= '0;
            r_fit_mode    <= FIT_FIRST;
            r_block_count <= '0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    CFG_FIT_MODE:    r_fit_mode    <= i_cfg_data[1:0];
                    CFG_BLOCK_COUNT: r_block_count <= i_cfg_data;
                    default: ;
                endcase
            end
            // a result leaving while a new one is loaded is handled in ST_UPDATE
            if (r_out_valid && !i_out_stall && (r_state != ST_UPDATE)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_IDLE: begin
                    if (w_req_xfer) begin
                        r_req_size <= SIZE_BITS'(i_size_value);
                        r_last     <= i_last_in_batch;
                        r_cnt      <= '0;
                        r_state    <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    r_cnt <= r_cnt + 1'b1;
                    if (w_scan_last) begin
                        r_state <= ST_UPDATE;
                    end
                end
                ST_UPDATE: begin
                    if (w_out_free) begin
                        r_out_valid    <= 1'b1;
                        r_allocated    <= w_last.found;
                        r_chosen       <= w_last.found ? CHOSEN_W'(w_last.best_idx) : '0;
                        r_remaining    <= w_last.found ? SIZE_W'(w_remain) : '0;
                        r_end_of_batch <= r_last;
                        r_state        <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_allocated      = r_allocated;
    assign o_chosen_block   = r_chosen;
    assign o_remaining_size = r_remaining;
    assign o_end_of_batch   = r_end_of_batch;

    // checks
    `ASSERT_NEXT(a_req_starts_scan, i_clk, i_rst_n, w_req_xfer, r_state == ST_SCAN)
    `ASSERT_NEXT(a_scan_ends, i_clk, i_rst_n, w_scan_last, r_state == ST_UPDATE)
    `ASSERT_IMPLIES(a_pick_fits, i_clk, i_rst_n, w_grant, w_last.best_val >= w_last.req_size)
    `ASSERT_IMPLIES(a_miss_zero, i_clk, i_rst_n, r_out_valid && !r_allocated,
        (r_chosen == '0) && (r_remaining == '0))
    `ASSERT_IMPLIES(a_no_table_write_scan, i_clk, i_rst_n, r_state == ST_SCAN, !w_wr.en)

endmodule
`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking testbench for fit_memory_block_allocator: directed and random load/request
// traffic checked against an in-bench placement predictor. Depends on fmba_pkg and the RTL.
`timescale 1ns / 1ps

module tb_top;
    import fmba_pkg::*;

    localparam int          PHASES         = 13;
    localparam int          PHASE_ITEMS    = 150;
    localparam int          SETTLE_CYCLES  = NUM_BLOCKS + 8;
    localparam int          LONG_HOLD      = 400;
    localparam int          WATCHDOG_LIMIT = 4000;
    localparam logic [1:0]  FIT_SPARE      = 2'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

    typedef struct packed {
        logic                  action;
        logic [LOAD_IDX_W-1:0] idx;
        logic [SIZE_W-1:0]     size;
        logic                  last;
    } t_alloc_item;

    typedef struct packed {
        logic                allocated;
        logic [CHOSEN_W-1:0] blk;
        logic [SIZE_W-1:0]   remain;
        logic                eob;
    } t_grant;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_stall;
    logic                  i_action        = ACT_LOAD;
    logic [LOAD_IDX_W-1:0] i_load_index    = '0;
    logic [SIZE_W-1:0]     i_size_value    = '0;
    logic                  i_last_in_batch = 1'b0;
    logic                  o_out_valid;
    logic                  i_out_stall     = 1'b0;
    logic                  o_allocated;
    logic [CHOSEN_W-1:0]   o_chosen_block;
    logic [SIZE_W-1:0]     o_remaining_size;
    logic                  o_end_of_batch;
    logic                  i_cfg_valid     = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index     = CFG_FIT_MODE;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;

    // predictor state
    logic [SIZE_W-1:0]     free_size [NUM_BLOCKS];
    logic [1:0]            sel_mode  = FIT_FIRST;
    logic [CFG_DATA_W-1:0] blk_count = '0;

    t_alloc_item req_backlog [$];
    t_grant      grant_q [$];
    t_alloc_item drv_item;
    t_alloc_item seen_item;
    t_grant      seen_grant;

    int unsigned in_offered   = 0;
    int unsigned in_taken     = 0;
    int unsigned hold_req     = 0;
    int unsigned hold_done    = 0;
    int          long_left    = 0;
    int          stall_left   = 0;
    int          send_gap     = 0;
    int          stuck_cycles = 0;
    bit          tail_quiet   = 1'b0;
    bit          failed       = 1'b0;
    bit          busy;

    // per-phase register settings; the last phase runs with no idling
    logic [1:0] ph_mode [PHASES] = '{FIT_FIRST, FIT_BEST, FIT_WORST, FIT_BEST, FIT_WORST,
                                     FIT_SPARE, FIT_FIRST, FIT_BEST, FIT_WORST, FIT_FIRST,
                                     FIT_BEST, FIT_WORST, FIT_WORST};
    logic [CFG_DATA_W-1:0] ph_count [PHASES] = '{5'd16, 5'd16, 5'd16, 5'd1, 5'd5, 5'd8,
                                                 5'd0, 5'd31, 5'd17, 5'd12, 5'd16, 5'd3,
                                                 5'd16};

    fit_memory_block_allocator dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_action         (i_action),
        .i_load_index     (i_load_index),
        .i_size_value     (i_size_value),
        .i_last_in_batch  (i_last_in_batch),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_allocated      (o_allocated),
        .o_chosen_block   (o_chosen_block),
        .o_remaining_size (o_remaining_size),
        .o_end_of_batch   (o_end_of_batch),
        .i_cfg_valid      (i_cfg_valid),
        .o_cfg_ready      (o_cfg_ready),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // apply one accepted item: loads update the table, requests place and queue a grant
    function automatic void predict_grant(input t_alloc_item it);
        int     limit;
        int     pick;
        int     j;
        t_grant g;
        if (it.action == ACT_LOAD) begin
            if (int'(it.idx) < NUM_BLOCKS) free_size[it.idx] = it.size;
            return;
        end
        limit = (int'(blk_count) > NUM_BLOCKS) ? NUM_BLOCKS : int'(blk_count);
        pick  = -1;
        for (j = 0; j < limit; j++) begin
            if (free_size[j] >= it.size) begin
                if (pick < 0) pick = j;
                else if (sel_mode == FIT_BEST && free_size[j] < free_size[pick]) pick = j;
                else if (sel_mode == FIT_WORST && free_size[j] > free_size[pick]) pick = j;
            end
        end
        g = '0;
        if (pick >= 0) begin
            free_size[pick] = free_size[pick] - it.size;
            g.allocated     = 1'b1;
            g.blk           = pick[CHOSEN_W-1:0];
            g.remain        = free_size[pick];
        end
        g.eob = it.last;
        grant_q.push_back(g);
    endfunction

    function automatic void check_field(input string name, input logic [SIZE_W-1:0] exp_v,
                                        input logic [SIZE_W-1:0] act_v);
        if (act_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            failed = 1'b1;
        end
    endfunction

    task automatic push_item(input logic act, input logic [LOAD_IDX_W-1:0] idx,
                             input logic [SIZE_W-1:0] size, input logic last);
        t_alloc_item it;
        it.action = act;
        it.idx    = idx;
        it.size   = size;
        it.last   = last;
        req_backlog.push_back(it);
    endtask

    // wait for every transfer and grant, then let a trailing load finish
    task automatic settle();
        while (req_backlog.size() != 0 || in_taken != in_offered || grant_q.size() != 0)
            @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // one register write; valid stays high for a following write. Entered at a falling edge.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_regs(input logic [1:0] mode, input logic [CFG_DATA_W-1:0] count,
                            input bit spare);
        cfg_write(CFG_FIT_MODE, {3'b000, mode});
        cfg_write(CFG_BLOCK_COUNT, count);
        if (spare) begin
            cfg_write(CFG_SPARE_A, 5'h1F);
            cfg_write(CFG_SPARE_B, 5'h00);
        end
        i_cfg_valid <= 1'b0;
    endtask

    // input driver: holds a stalled transfer, otherwise inserts a random gap or takes the next backlog item
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (i_in_valid && in_taken != in_offered) begin
            // still waiting for this transfer
        end else if (send_gap > 0) begin
            send_gap--;
            i_in_valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
            drv_item = req_backlog.pop_front();
            i_action        <= drv_item.action;
            i_load_index    <= drv_item.idx;
            i_size_value    <= drv_item.size;
            i_last_in_batch <= drv_item.last;
            i_in_valid      <= 1'b1;
            in_offered++;
            if (!tail_quiet && $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 8);
        end else begin
            i_in_valid <= 1'b0;
        end
    end

    // result receiver: short random stall bursts, plus a long hold-off on request
    always @(negedge i_clk) begin
        if (hold_done != hold_req && long_left == 0) long_left = LONG_HOLD;
        if (long_left > 0) begin
            long_left--;
            i_out_stall <= 1'b1;
            if (long_left == 0) hold_done++;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if (!tail_quiet && $urandom_range(0, 7) == 0) begin
            stall_left = $urandom_range(1, 8) - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // monitor: checks result transfers, feeds the predictor, runs the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            busy = 1'b0;
            if (o_out_valid && !i_out_stall) begin
                busy = 1'b1;
                if (grant_q.size() == 0) begin
                    $error("result transfer with no request pending");
                    failed = 1'b1;
                end else begin
                    seen_grant = grant_q.pop_front();
                    check_field("allocated", seen_grant.allocated, o_allocated);
                    check_field("chosen_block", seen_grant.blk, o_chosen_block);
                    check_field("remaining_size", seen_grant.remain, o_remaining_size);
                    check_field("end_of_batch", seen_grant.eob, o_end_of_batch);
                end
            end
            if (i_cfg_valid && o_cfg_ready) begin
                busy = 1'b1;
                case (i_cfg_index)
                    CFG_FIT_MODE:    sel_mode = i_cfg_data[1:0];
                    CFG_BLOCK_COUNT: blk_count = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && !o_in_stall) begin
                busy = 1'b1;
                seen_item.action = i_action;
                seen_item.idx    = i_load_index;
                seen_item.size   = i_size_value;
                seen_item.last   = i_last_in_batch;
                in_taken++;
                predict_grant(seen_item);
            end
            stuck_cycles = busy ? 0 : stuck_cycles + 1;
            if (stuck_cycles >= WATCHDOG_LIMIT) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    // stimulus sequence
    initial begin
        logic [SIZE_W-1:0] sz;
        int                ph;
        int                n;
        int                r;
        for (n = 0; n < NUM_BLOCKS; n++) free_size[n] = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // zero block count after reset: no block takes part in the scan, request is refused
        push_item(ACT_REQUEST, 4'hA, 16'h0005, 1'b1);
        settle();

        // oversized count saturates; spare mode acts as first fit; spare indexes ignored
        set_regs(FIT_SPARE, 5'd31, 1'b1);
        push_item(ACT_LOAD, 4'd0, 16'h0000, 1'b1);
        push_item(ACT_LOAD, 4'd1, 16'hFFFF, 1'b0);
        push_item(ACT_LOAD, 4'd2, 16'h0010, 1'b1);
        push_item(ACT_LOAD, 4'd3, 16'h0010, 1'b0);
        push_item(ACT_LOAD, 4'd4, 16'h8000, 1'b0);
        push_item(ACT_LOAD, 4'd5, 16'h0001, 1'b0);
        push_item(ACT_LOAD, 4'd6, 16'h7FFF, 1'b0);
        push_item(ACT_LOAD, 4'd7, 16'h0010, 1'b0);
        for (n = 8; n < NUM_BLOCKS; n++)
            push_item(ACT_LOAD, n[LOAD_IDX_W-1:0], 16'h0020 << (n - 8), 1'b0);
        push_item(ACT_REQUEST, 4'h0, 16'h0000, 1'b0);  // zero-size request
        push_item(ACT_REQUEST, 4'hF, 16'hFFFF, 1'b1);  // exact fit at the top of range
        push_item(ACT_REQUEST, 4'h5, 16'hFFFF, 1'b0);  // nothing left that large
        push_item(ACT_REQUEST, 4'h3, 16'h0010, 1'b1);
        settle();

        // random phases across placement modes and block counts
        for (ph = 0; ph < PHASES; ph++) begin
            set_regs(ph_mode[ph], ph_count[ph], ph == 6);
            if (ph == PHASES - 1) tail_quiet = 1'b1;
            if (ph == 2) hold_req++;
            for (n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 9);
                if ($urandom_range(0, 99) < 35) begin
                    if (r < 6)       sz = 16'($urandom_range(0, 1023));
                    else if (r < 8)  sz = 16'($urandom_range(1, 4) * 256);
                    else if (r == 8) sz = 16'($urandom);
                    else             sz = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    push_item(ACT_LOAD, 4'($urandom_range(0, 15)), sz, 1'($urandom));
                end else begin
                    if (r < 7)       sz = 16'($urandom_range(0, 400));
                    else if (r == 7) sz = 16'($urandom_range(0, 40));
                    else if (r == 8) sz = 16'($urandom);
                    else             sz = $urandom_range(0, 1) ? 16'hFFFF : 16'h0000;
                    push_item(ACT_REQUEST, 4'($urandom_range(0, 15)), sz, 1'($urandom));
                end
            end
            settle();
        end

        if (!failed && grant_q.size() == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule
